>>> rtl/rasm_pkg.sv
`timescale 1ns / 1ps

package rasm_pkg;

    localparam int CFG_W       = 16;
    localparam int IDX_W       = 3;
    localparam int MAX_WRITES  = 14;
    localparam int CNT_W       = 4;
    localparam int TAG_W       = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [15:0] aileron_cmd;
        logic signed [15:0] elevator_cmd;
        logic signed [15:0] rudder_cmd;
        logic signed [15:0] flap_cmd;
        logic signed [15:0] brake_cmd;
    } cmd_t;

    typedef struct packed {
        logic [3:0]         servo_channel;
        logic signed [15:0] servo_value;
        logic               last_write;
    } result_t;

    // what a write carries: a raw command, one mixed term, or a sum or difference of two
    typedef enum logic [3:0] {
        SRC_AIL,
        SRC_T1,
        SRC_T2,
        SRC_EV_P,
        SRC_EV_N,
        SRC_AV_P,
        SRC_AV_N,
        SRC_VSUM,
        SRC_VDIF,
        SRC_ELE,
        SRC_RUD,
        SRC_W1,
        SRC_W2,
        SRC_FLP,
        SRC_BRK
    } src_t;

    typedef struct packed {
        logic [3:0] chan;
        src_t       src;
    } slot_t;

    typedef struct packed {
        cmd_t                         cmd;
        logic signed [8:0]            rate_a;
        logic signed [8:0]            rate_e;
        logic signed [8:0]            rate_r;
        logic signed [8:0]            ail_diff;
        logic signed [8:0]            x_diff;
        logic signed [8:0]            wd_pos;
        logic signed [8:0]            wd_neg;
        slot_t [MAX_WRITES-1:0]       slots;
        logic [CNT_W-1:0]             count;
    } item_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic               is_diff;
        logic signed [15:0] v;
        logic signed [8:0]  k;
    } mix_req_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic signed [15:0] value;
    } mix_rsp_t;

endpackage

>>> rtl/rasm_front.sv
`timescale 1ns / 1ps

module rasm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          full,
    input  rasm_pkg::cmd_t                cmd,
    input  logic                          wr_en,
    input  logic [rasm_pkg::IDX_W-1:0]    wr_index,
    input  logic [rasm_pkg::CFG_W-1:0]    wr_data,
    output logic                          push,
    output rasm_pkg::item_t               push_item
);
    import rasm_pkg::*;

    localparam logic [IDX_W-1:0] REG_LAYOUT    = 3'd0;
    localparam logic [IDX_W-1:0] REG_AIL_DIFF  = 3'd1;
    localparam logic [IDX_W-1:0] REG_WING_DIFF = 3'd2;
    localparam logic [IDX_W-1:0] REG_ELEVON    = 3'd3;
    localparam logic [IDX_W-1:0] REG_AILEVATOR = 3'd4;
    localparam logic [IDX_W-1:0] REG_VTAIL     = 3'd5;

    localparam logic [1:0] TAIL_VTAIL     = 2'd1;
    localparam logic [1:0] TAIL_AILEVATOR = 2'd2;
    localparam logic [1:0] RUD_NONE       = 2'd0;
    localparam logic [1:0] RUD_WINGLET    = 2'd2;
    localparam logic [1:0] AILS_TWO       = 2'd1;
    localparam logic [1:0] AILS_FOUR      = 2'd2;
    localparam logic [1:0] FLAPS_NONE     = 2'd0;
    localparam logic [1:0] FLAPS_TWO      = 2'd2;
    localparam logic [1:0] FLAPS_FOUR     = 2'd3;
    localparam logic [1:0] BRAKES_ONE     = 2'd1;
    localparam logic [1:0] BRAKES_TWO     = 2'd2;

    localparam logic [3:0] CH_AIL1 = 4'd0;
    localparam logic [3:0] CH_AIL2 = 4'd1;
    localparam logic [3:0] CH_AIL3 = 4'd2;
    localparam logic [3:0] CH_AIL4 = 4'd3;
    localparam logic [3:0] CH_ELE1 = 4'd4;
    localparam logic [3:0] CH_ELE2 = 4'd5;
    localparam logic [3:0] CH_RUD1 = 4'd6;
    localparam logic [3:0] CH_RUD2 = 4'd7;
    localparam logic [3:0] CH_FLP1 = 4'd8;
    localparam logic [3:0] CH_FLP2 = 4'd9;
    localparam logic [3:0] CH_FLP3 = 4'd10;
    localparam logic [3:0] CH_FLP4 = 4'd11;
    localparam logic [3:0] CH_BRK1 = 4'd12;
    localparam logic [3:0] CH_BRK2 = 4'd13;

    logic [10:0] layout_reg;
    logic [7:0]  ail_diff_reg;
    logic [7:0]  wing_diff_reg;
    logic [15:0] elevon_reg;
    logic [15:0] ailevator_reg;
    logic [15:0] vtail_reg;

    logic        tailless;
    logic [1:0]  tail;
    logic [1:0]  rud_kind;
    logic [1:0]  ails;
    logic [1:0]  flaps;
    logic [1:0]  brakes;

    slot_t [MAX_WRITES-1:0] plan_slots;
    logic [CNT_W-1:0]       plan_count;

    function automatic logic signed [8:0] sx9(input logic [7:0] b);
        return $signed({b[7], b});
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg    <= 11'd8;
            ail_diff_reg  <= 8'd0;
            wing_diff_reg <= 8'd0;
            elevon_reg    <= 16'h3232;
            ailevator_reg <= 16'h0032;
            vtail_reg     <= 16'h3232;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_LAYOUT:    layout_reg    <= wr_data[10:0];
                REG_AIL_DIFF:  ail_diff_reg  <= wr_data[7:0];
                REG_WING_DIFF: wing_diff_reg <= wr_data[7:0];
                REG_ELEVON:    elevon_reg    <= wr_data;
                REG_AILEVATOR: ailevator_reg <= wr_data;
                REG_VTAIL:     vtail_reg     <= wr_data;
                default:       ;
            endcase
        end
    end

    assign tailless = layout_reg[0];
    assign tail     = layout_reg[2:1];
    assign rud_kind = layout_reg[4:3];
    assign ails     = layout_reg[6:5];
    assign flaps    = layout_reg[8:7];
    assign brakes   = layout_reg[10:9];

    // write list in output order, packed from slot 0 up
    always_comb
    begin
        logic [CNT_W-1:0] n;
        n          = '0;
        plan_slots = '0;
        if (!tailless)
        begin
            if (ails == AILS_FOUR)
            begin
                plan_slots[n] = '{CH_AIL4, SRC_T2}; n = n + 1'b1;
                plan_slots[n] = '{CH_AIL3, SRC_T1}; n = n + 1'b1;
            end
            if (ails == AILS_TWO || ails == AILS_FOUR)
            begin
                plan_slots[n] = '{CH_AIL2, SRC_T2}; n = n + 1'b1;
                plan_slots[n] = '{CH_AIL1, SRC_T1}; n = n + 1'b1;
            end
            else
            begin
                plan_slots[n] = '{CH_AIL1, SRC_AIL}; n = n + 1'b1;
            end
            if (tail == TAIL_VTAIL)
            begin
                plan_slots[n] = '{CH_ELE1, SRC_VSUM}; n = n + 1'b1;
                plan_slots[n] = '{CH_RUD2, SRC_VSUM}; n = n + 1'b1;
                plan_slots[n] = '{CH_RUD1, SRC_VDIF}; n = n + 1'b1;
                plan_slots[n] = '{CH_ELE2, SRC_VDIF}; n = n + 1'b1;
            end
            else if (tail == TAIL_AILEVATOR)
            begin
                plan_slots[n] = '{CH_ELE1, SRC_AV_P}; n = n + 1'b1;
                plan_slots[n] = '{CH_ELE2, SRC_AV_N}; n = n + 1'b1;
                plan_slots[n] = '{CH_RUD1, SRC_RUD};  n = n + 1'b1;
            end
            else
            begin
                plan_slots[n] = '{CH_ELE1, SRC_ELE}; n = n + 1'b1;
                plan_slots[n] = '{CH_RUD1, SRC_RUD}; n = n + 1'b1;
            end
        end
        else
        begin
            if (ails == AILS_FOUR)
            begin
                plan_slots[n] = '{CH_AIL4, SRC_EV_N}; n = n + 1'b1;
                plan_slots[n] = '{CH_AIL3, SRC_EV_P}; n = n + 1'b1;
            end
            plan_slots[n] = '{CH_AIL2, SRC_EV_N}; n = n + 1'b1;
            plan_slots[n] = '{CH_AIL1, SRC_EV_P}; n = n + 1'b1;
            if (rud_kind == RUD_WINGLET)
            begin
                plan_slots[n] = '{CH_RUD1, SRC_W1}; n = n + 1'b1;
                plan_slots[n] = '{CH_RUD2, SRC_W2}; n = n + 1'b1;
            end
            else if (rud_kind != RUD_NONE)
            begin
                plan_slots[n] = '{CH_RUD1, SRC_RUD}; n = n + 1'b1;
            end
        end
        // four flaps: outer pair follows the brake
        if (flaps == FLAPS_FOUR)
        begin
            plan_slots[n] = '{CH_FLP4, SRC_BRK}; n = n + 1'b1;
            plan_slots[n] = '{CH_FLP3, SRC_BRK}; n = n + 1'b1;
        end
        if (flaps == FLAPS_TWO || flaps == FLAPS_FOUR)
        begin
            plan_slots[n] = '{CH_FLP2, SRC_FLP}; n = n + 1'b1;
        end
        if (flaps != FLAPS_NONE)
        begin
            plan_slots[n] = '{CH_FLP1, SRC_FLP}; n = n + 1'b1;
        end
        if (brakes == BRAKES_TWO)
        begin
            plan_slots[n] = '{CH_BRK2, SRC_BRK}; n = n + 1'b1;
        end
        if (brakes == BRAKES_ONE || brakes == BRAKES_TWO)
        begin
            plan_slots[n] = '{CH_BRK1, SRC_BRK}; n = n + 1'b1;
        end
        plan_count = n;
    end

    always_comb
    begin
        push_item.cmd      = cmd;
        push_item.rate_a   = tailless ? sx9(elevon_reg[7:0])  : sx9(ailevator_reg[7:0]);
        push_item.rate_e   = tailless ? sx9(elevon_reg[15:8]) : sx9(vtail_reg[7:0]);
        push_item.rate_r   = sx9(vtail_reg[15:8]);
        push_item.ail_diff = sx9(ail_diff_reg);
        push_item.x_diff   = tailless ? sx9(ail_diff_reg) : sx9(ailevator_reg[15:8]);
        push_item.wd_pos   = sx9(wing_diff_reg);
        // second winglet: full-width negation, -(-128) stays +128
        push_item.wd_neg   = 9'sd0 - sx9(wing_diff_reg);
        push_item.slots    = plan_slots;
        push_item.count    = plan_count;
    end

    assign push = start && !full;

endmodule

>>> rtl/rasm_queue.sv
`timescale 1ns / 1ps

module rasm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rasm_pkg::item_t push_item,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output rasm_pkg::item_t head
);
    import rasm_pkg::*;

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue read while empty");

endmodule

>>> rtl/rasm_mix.sv
`timescale 1ns / 1ps

// v * rate / 100 truncated toward zero, saturated; diff ops pass v when
// no reduction applies. Three stages: multiply, reciprocal, correct.
module rasm_mix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  rasm_pkg::mix_req_t req,
    output logic               rsp_valid,
    output rasm_pkg::mix_rsp_t rsp
);
    import rasm_pkg::*;

    // 5243 / 2^19 overshoots 1/100 by less than one unit for |p| <= 2^22
    localparam logic [12:0] RECIP     = 13'd5243;
    localparam int          RECIP_SH  = 19;

    logic [8:0]         kabs;
    logic signed [9:0]  rate;
    logic               bypass;

    logic               s1_valid_reg;
    logic [TAG_W-1:0]   s1_tag_reg;
    logic               s1_bypass_reg;
    logic signed [15:0] s1_v_reg;
    logic signed [25:0] s1_p_reg;

    logic [25:0]        mag;
    logic [35:0]        scaled;

    logic               s2_valid_reg;
    logic [TAG_W-1:0]   s2_tag_reg;
    logic               s2_bypass_reg;
    logic signed [15:0] s2_v_reg;
    logic               s2_neg_reg;
    logic [22:0]        s2_n_reg;
    logic [15:0]        s2_q0_reg;

    logic [22:0]        hund;
    logic               over;
    logic [15:0]        q;
    logic [15:0]        q_neg;
    logic signed [15:0] sat_val;

    logic               rsp_valid_reg;
    mix_rsp_t           rsp_reg;

    always_comb
    begin
        kabs   = req.k[8] ? 9'(-req.k) : 9'(req.k);
        rate   = req.is_diff ? (10'sd100 - $signed({1'b0, kabs}))
                             : $signed({req.k[8], req.k});
        // opposite signs only: zero or same sign leaves v alone
        bypass = req.is_diff && (req.k == '0 || req.v == '0 || req.v[15] == req.k[8]);
    end

    always_comb
    begin
        mag    = s1_p_reg[25] ? 26'(-s1_p_reg) : 26'(s1_p_reg);
        scaled = mag[22:0] * RECIP;
    end

    always_comb
    begin
        hund  = s2_q0_reg * 7'd100;
        over  = hund > s2_n_reg;
        q     = s2_q0_reg - {15'd0, over};
        q_neg = ~q + 16'd1;
        if (!s2_neg_reg)
            sat_val = (q > 16'd32767) ? 16'sh7FFF : $signed(q);
        else
            sat_val = (q > 16'd32768) ? 16'sh8000 : $signed(q_neg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= req_valid;
            s2_valid_reg  <= s1_valid_reg;
            rsp_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg    <= req.tag;
        s1_bypass_reg <= bypass;
        s1_v_reg      <= req.v;
        s1_p_reg      <= req.v * rate;

        s2_tag_reg    <= s1_tag_reg;
        s2_bypass_reg <= s1_bypass_reg;
        s2_v_reg      <= s1_v_reg;
        s2_neg_reg    <= s1_p_reg[25];
        s2_n_reg      <= mag[22:0];
        s2_q0_reg     <= scaled[RECIP_SH+15:RECIP_SH];

        rsp_reg.tag   <= s2_tag_reg;
        rsp_reg.value <= s2_bypass_reg ? s2_v_reg : sat_val;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid |-> ##3 rsp_valid)
        else $error("mix result missing three cycles after issue");

endmodule

>>> rtl/rasm_back.sv
`timescale 1ns / 1ps

module rasm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  rasm_pkg::item_t   q_item,
    output logic              pop,
    output logic              strobe,
    output rasm_pkg::result_t result
);
    import rasm_pkg::*;

    localparam int NUM_OPS = 9;
    localparam logic [TAG_W-1:0] OP_MA = 4'd0;
    localparam logic [TAG_W-1:0] OP_ME = 4'd1;
    localparam logic [TAG_W-1:0] OP_MR = 4'd2;
    localparam logic [TAG_W-1:0] OP_W1 = 4'd3;
    localparam logic [TAG_W-1:0] OP_W2 = 4'd4;
    localparam logic [TAG_W-1:0] OP_T1 = 4'd5;
    localparam logic [TAG_W-1:0] OP_T2 = 4'd6;
    localparam logic [TAG_W-1:0] OP_X1 = 4'd7;
    localparam logic [TAG_W-1:0] OP_X2 = 4'd8;

    typedef enum logic [1:0] {PS_IDLE, PS_RUN, PS_WAIT} prep_state_t;

    prep_state_t        prep_state_reg;
    item_t              prep_item_reg;
    logic [TAG_W-1:0]   op_reg;
    logic signed [15:0] res_reg [NUM_OPS];
    logic [NUM_OPS-1:0] res_ok_reg;

    logic               issue;
    mix_req_t           req;
    logic               rsp_valid;
    mix_rsp_t           rsp;
    logic               handoff;

    logic               em_active_reg;
    item_t              em_item_reg;
    logic signed [15:0] em_res_reg [NUM_OPS];
    logic [CNT_W-1:0]   em_idx_reg;
    logic               em_last;
    slot_t              slot;
    logic signed [15:0] value;

    logic               strobe_reg;
    result_t            result_reg;

    function automatic logic signed [15:0] neg_sat(input logic signed [15:0] a);
        return (a == 16'sh8000) ? 16'sh7FFF : -a;
    endfunction

    function automatic logic signed [15:0] clip17(input logic signed [16:0] s);
        if (s > 17'sd32767)
            return 16'sh7FFF;
        else if (s < -17'sd32768)
            return 16'sh8000;
        else
            return $signed(s[15:0]);
    endfunction

    function automatic logic signed [15:0] add_sat(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
        return clip17($signed({a[15], a}) + $signed({b[15], b}));
    endfunction

    function automatic logic signed [15:0] sub_sat(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
        return clip17($signed({a[15], a}) - $signed({b[15], b}));
    endfunction

    // ---------------- prep: nine mix/diff ops per item ----------------

    // second-round diffs need the first mixed aileron term back
    assign issue = (prep_state_reg == PS_RUN) && (op_reg < OP_X1 || res_ok_reg[OP_MA]);
    assign pop   = (prep_state_reg == PS_IDLE) && q_valid;

    always_comb
    begin
        req.tag     = op_reg;
        req.is_diff = 1'b1;
        req.v       = prep_item_reg.cmd.aileron_cmd;
        req.k       = prep_item_reg.ail_diff;
        unique case (op_reg)
            OP_MA:
            begin
                req.is_diff = 1'b0;
                req.k       = prep_item_reg.rate_a;
            end
            OP_ME:
            begin
                req.is_diff = 1'b0;
                req.v       = prep_item_reg.cmd.elevator_cmd;
                req.k       = prep_item_reg.rate_e;
            end
            OP_MR:
            begin
                req.is_diff = 1'b0;
                req.v       = prep_item_reg.cmd.rudder_cmd;
                req.k       = prep_item_reg.rate_r;
            end
            OP_W1:
            begin
                req.v = prep_item_reg.cmd.rudder_cmd;
                req.k = prep_item_reg.wd_pos;
            end
            OP_W2:
            begin
                req.v = prep_item_reg.cmd.rudder_cmd;
                req.k = prep_item_reg.wd_neg;
            end
            OP_T1: ;
            OP_T2: req.v = neg_sat(prep_item_reg.cmd.aileron_cmd);
            OP_X1:
            begin
                req.v = res_reg[OP_MA];
                req.k = prep_item_reg.x_diff;
            end
            OP_X2:
            begin
                req.v = neg_sat(res_reg[OP_MA]);
                req.k = prep_item_reg.x_diff;
            end
            default: ;
        endcase
    end

    rasm_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (issue),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    assign em_last = em_active_reg && (em_idx_reg == em_item_reg.count - 4'd1);
    assign handoff = (prep_state_reg == PS_WAIT) && (&res_ok_reg)
                     && (!em_active_reg || em_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_state_reg <= PS_IDLE;
            op_reg         <= '0;
            res_ok_reg     <= '0;
        end
        else
        begin
            if (rsp_valid)
                res_ok_reg[rsp.tag] <= 1'b1;
            unique case (prep_state_reg)
                PS_IDLE:
                begin
                    if (q_valid)
                    begin
                        res_ok_reg     <= '0;
                        op_reg         <= OP_MA;
                        prep_state_reg <= PS_RUN;
                    end
                end
                PS_RUN:
                begin
                    if (issue)
                    begin
                        op_reg <= op_reg + 1'b1;
                        if (op_reg == OP_X2)
                            prep_state_reg <= PS_WAIT;
                    end
                end
                PS_WAIT:
                begin
                    if (handoff)
                        prep_state_reg <= PS_IDLE;
                end
                default: prep_state_reg <= PS_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            prep_item_reg <= q_item;
        if (rsp_valid)
            res_reg[rsp.tag] <= rsp.value;
    end

    // ---------------- emit: one write per cycle ----------------

    assign slot = em_item_reg.slots[em_idx_reg];

    always_comb
    begin
        unique case (slot.src)
            SRC_AIL:  value = em_item_reg.cmd.aileron_cmd;
            SRC_T1:   value = em_res_reg[OP_T1];
            SRC_T2:   value = em_res_reg[OP_T2];
            SRC_EV_P: value = add_sat(em_res_reg[OP_ME], em_res_reg[OP_X1]);
            SRC_EV_N: value = add_sat(em_res_reg[OP_ME], em_res_reg[OP_X2]);
            SRC_AV_P: value = add_sat(em_item_reg.cmd.elevator_cmd, em_res_reg[OP_X1]);
            SRC_AV_N: value = add_sat(em_item_reg.cmd.elevator_cmd, em_res_reg[OP_X2]);
            SRC_VSUM: value = add_sat(em_res_reg[OP_MR], em_res_reg[OP_ME]);
            SRC_VDIF: value = sub_sat(em_res_reg[OP_MR], em_res_reg[OP_ME]);
            SRC_ELE:  value = em_item_reg.cmd.elevator_cmd;
            SRC_RUD:  value = em_item_reg.cmd.rudder_cmd;
            SRC_W1:   value = em_res_reg[OP_W1];
            SRC_W2:   value = em_res_reg[OP_W2];
            SRC_FLP:  value = em_item_reg.cmd.flap_cmd;
            SRC_BRK:  value = em_item_reg.cmd.brake_cmd;
            default:  value = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_active_reg <= 1'b0;
            em_idx_reg    <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            strobe_reg <= em_active_reg;
            if (handoff)
            begin
                em_active_reg <= 1'b1;
                em_idx_reg    <= '0;
            end
            else if (em_active_reg)
            begin
                if (em_last)
                begin
                    em_active_reg <= 1'b0;
                    em_idx_reg    <= '0;
                end
                else
                    em_idx_reg <= em_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (em_active_reg)
        begin
            result_reg.servo_channel <= slot.chan;
            result_reg.servo_value   <= value;
            result_reg.last_write    <= em_last;
        end
        if (handoff)
        begin
            em_item_reg <= prep_item_reg;
            em_res_reg  <= res_reg;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    a_rsp_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> prep_state_reg != PS_IDLE)
        else $error("mix result arrived with no item in prep");

    a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && result_reg.last_write) |-> em_idx_reg == '0)
        else $error("write index not rewound after last write");

    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> result_reg.servo_channel <= 4'd13)
        else $error("write to a channel that does not exist");

endmodule

>>> rtl/rc_airframe_servo_mixer_top.sv
`timescale 1ns / 1ps

// Servo mixer for tailed and tailless airframes. A start beat is taken at
// any edge where busy is low; busy only rises when the two-entry input
// queue is full. Each item is turned into 2 to 14 channel writes, shown one
// per cycle on result with strobe high for exactly one cycle; the receiver
// cannot hold them off, and last_write marks the final write of an item.
// On an idle block the first write passes the input queue, the prep stage,
// the mix unit and the emit bank before it reaches result. The prep stage
// issues nine mix/differential operations one per cycle, the last two only
// once the mixed aileron term is back, into a three-stage multiply and
// divide-by-100 unit, and a second bank drains writes while the next item
// is prepared. Layout and rates are written through wr_en/wr_index/wr_data
// and must only change while no item is in flight.
module rc_airframe_servo_mixer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rasm_pkg::cmd_t                cmd,
    output logic                          strobe,
    output rasm_pkg::result_t             result,
    input  logic                          wr_en,
    input  logic [rasm_pkg::IDX_W-1:0]    wr_index,
    input  logic [rasm_pkg::CFG_W-1:0]    wr_data
);
    import rasm_pkg::*;

    logic  push;
    item_t push_item;
    logic  full;
    logic  not_empty;
    logic  pop;
    item_t head;

    rasm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .full      (full),
        .cmd       (cmd),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .push      (push),
        .push_item (push_item)
    );

    rasm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    rasm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (not_empty),
        .q_item  (head),
        .pop     (pop),
        .strobe  (strobe),
        .result  (result)
    );

    assign busy = full;

endmodule
